>>> sv/nearest_neighbor_resampler_macros.svh
// Assertion macros for the checker file.
`ifndef NEAREST_NEIGHBOR_RESAMPLER_MACROS_SVH
`define NEAREST_NEIGHBOR_RESAMPLER_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted
`define NNR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted
`define NNR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset
`define NNR_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/nnr_pkg.sv
`timescale 1ns / 1ps

package nnr_pkg;

    // rate registers and phase accumulator
    localparam int RATE_W = 18;
    localparam int REM_W  = 19;
    localparam int STEP_W = 5;

    localparam logic [RATE_W-1:0] OLD_RATE_RESET = 18'd44100;
    localparam logic [RATE_W-1:0] NEW_RATE_RESET = 18'd44100;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OLD_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_RATE = 1'b1;

    // command queue between front and back
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = 1;
    localparam int CMD_CNT_W = 2;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_DONE
    } t_front_state;

    // queue occupancy as seen by its neighbors
    typedef struct packed {
        logic full;
        logic empty;
    } t_cmd_status;

endpackage

>>> sv/nnr_front.sv
`timescale 1ns / 1ps

module nnr_front #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int MAX_COPIES   = 64,
    parameter int CNT_W        = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic [nnr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [nnr_pkg::RATE_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [SAMPLE_WIDTH-1:0]       i_in_sample,
    input  logic                          i_in_last,
    input  nnr_pkg::t_cmd_status          i_cmd_stat,
    output logic                          o_push,
    output logic [SAMPLE_WIDTH-1:0]       o_cmd_sample,
    output logic [CNT_W-1:0]              o_cmd_count
);

    localparam int RW = nnr_pkg::RATE_W;
    localparam int QW = nnr_pkg::REM_W;

    nnr_pkg::t_front_state r_state, n_state;

    logic [RW-1:0]                r_old_rate;
    logic [RW-1:0]                r_new_rate;
    logic [QW-1:0]                r_phase;
    logic [SAMPLE_WIDTH-1:0]      r_sample;
    logic                         r_last;
    logic                         r_hit;
    logic [RW-1:0]                r_quo;
    logic [QW-1:0]                r_part;
    logic [nnr_pkg::STEP_W-1:0]   r_step;

    logic [RW-1:0] w_old_eff;
    logic          w_accept;
    logic          w_hit;
    logic [QW-1:0] w_trial;
    logic          w_ge;
    logic          w_div_end;
    logic          w_rem_nz;
    logic [QW-1:0] w_copies;
    logic [QW-1:0] w_phase_nx;
    logic [QW-1:0] w_copies_adj;
    logic [QW-1:0] w_phase_adj;
    logic          w_has_copy;
    logic          w_done_go;

    // a zero old rate counts as one
    assign w_old_eff = (r_old_rate == '0) ? RW'(1) : r_old_rate;
    assign w_accept  = i_in_valid && o_in_ready;
    assign w_hit     = {1'b0, r_new_rate} > r_phase;

    // restoring divide, one quotient bit per cycle
    assign w_trial   = {r_part[RW-1:0], r_quo[RW-1]};
    assign w_ge      = w_trial >= {1'b0, w_old_eff};
    assign w_div_end = (r_step == nnr_pkg::STEP_W'(RW - 1));

    // copies = ceil(d/o); new phase is the distance to the next output slot
    always_comb begin
        w_rem_nz = (r_part != '0);
        if (r_hit) begin
            w_copies   = {1'b0, r_quo} + QW'(w_rem_nz);
            w_phase_nx = w_rem_nz ? ({1'b0, w_old_eff} - r_part) : '0;
        end else begin
            w_copies   = '0;
            w_phase_nx = r_phase - {1'b0, r_new_rate};
        end
        w_copies_adj = w_copies;
        w_phase_adj  = w_phase_nx;
        // end of stream: drop the trailing partial copy
        if (r_last) begin
            if ((w_phase_nx != '0) && (w_copies != '0)) begin
                w_copies_adj = w_copies - QW'(1);
            end
            w_phase_adj = '0;
        end
    end

    assign w_has_copy = (w_copies_adj != '0);
    assign w_done_go  = !w_has_copy || !i_cmd_stat.full;

    // saturate the emitted count
    assign o_cmd_count  = (w_copies_adj > QW'(MAX_COPIES)) ? CNT_W'(MAX_COPIES)
                                                           : CNT_W'(w_copies_adj);
    assign o_cmd_sample = r_sample;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nnr_pkg::FR_IDLE: begin
                if (i_in_valid) begin
                    n_state = w_hit ? nnr_pkg::FR_DIV : nnr_pkg::FR_DONE;
                end
            end
            nnr_pkg::FR_DIV: begin
                if (w_div_end) begin
                    n_state = nnr_pkg::FR_DONE;
                end
            end
            nnr_pkg::FR_DONE: begin
                if (w_done_go) begin
                    n_state = nnr_pkg::FR_IDLE;
                end
            end
            default: n_state = nnr_pkg::FR_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_push     = 1'b0;
        unique case (r_state)
            nnr_pkg::FR_IDLE: o_in_ready = 1'b1;
            nnr_pkg::FR_DIV:  o_in_ready = 1'b0;
            nnr_pkg::FR_DONE: o_push     = w_has_copy && !i_cmd_stat.full;
            default:          o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nnr_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // rate registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_rate <= nnr_pkg::OLD_RATE_RESET;
            r_new_rate <= nnr_pkg::NEW_RATE_RESET;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                nnr_pkg::CFG_OLD_RATE: r_old_rate <= i_cfg_data;
                nnr_pkg::CFG_NEW_RATE: r_new_rate <= i_cfg_data;
                default:               r_old_rate <= r_old_rate;
            endcase
        end
    end

    // phase accumulator advances once the word is queued, or has no copy to queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if ((r_state == nnr_pkg::FR_DONE) && w_done_go) begin
            r_phase <= w_phase_adj;
        end
    end

    // item capture and divider datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_in_sample;
            r_last   <= i_in_last;
            r_hit    <= w_hit;
            r_quo    <= RW'({1'b0, r_new_rate} - r_phase);
            r_part   <= '0;
            r_step   <= '0;
        end else if (r_state == nnr_pkg::FR_DIV) begin
            r_quo  <= {r_quo[RW-2:0], w_ge};
            r_part <= w_ge ? (w_trial - {1'b0, w_old_eff}) : w_trial;
            r_step <= r_step + 1'b1;
        end
    end

endmodule

>>> sv/nnr_cmd_fifo.sv
`timescale 1ns / 1ps

module nnr_cmd_fifo #(
    parameter int WIDTH = 23
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_data,
    output nnr_pkg::t_cmd_status o_stat
);

    logic [WIDTH-1:0]              r_mem [nnr_pkg::CMD_DEPTH];
    logic [nnr_pkg::CMD_PTR_W-1:0] r_wptr;
    logic [nnr_pkg::CMD_PTR_W-1:0] r_rptr;
    logic [nnr_pkg::CMD_CNT_W-1:0] r_cnt;

    assign o_stat.full  = (r_cnt == nnr_pkg::CMD_CNT_W'(nnr_pkg::CMD_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_data       = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> sv/nnr_back.sv
`timescale 1ns / 1ps

module nnr_back #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int CNT_W        = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  nnr_pkg::t_cmd_status    i_cmd_stat,
    input  logic [SAMPLE_WIDTH-1:0] i_cmd_sample,
    input  logic [CNT_W-1:0]        i_cmd_count,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [SAMPLE_WIDTH-1:0] o_sample,
    output logic                    o_last
);

    logic                    r_valid;
    logic [SAMPLE_WIDTH-1:0] r_sample;
    logic [CNT_W-1:0]        r_left;

    logic w_final;

    // copy on the port is the last of its run
    assign w_final = (r_left == CNT_W'(1));
    assign o_pop   = !i_cmd_stat.empty && (!r_valid || (i_ready && w_final));

    assign o_valid  = r_valid;
    assign o_sample = r_sample;
    assign o_last   = w_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (r_valid && i_ready && w_final) begin
            r_valid <= 1'b0;
        end
    end

    // load a run, then count it down one word at a time
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sample <= i_cmd_sample;
            r_left   <= i_cmd_count;
        end else if (r_valid && i_ready) begin
            r_left <= r_left - 1'b1;
        end
    end

endmodule

>>> sv/nearest_neighbor_resampler.sv
`timescale 1ns / 1ps

// Nearest-neighbor sample-rate converter for one channel. Each input word is
// copied zero or more times so that output j carries input
// floor(j*old_rate/new_rate); the word flagged tlast ends the stream, drops the
// trailing partial copy and clears the phase. Output tlast marks the final copy
// of each input; a run is capped at MAX_COPIES copies. The front end accepts a
// word, runs a restoring divide for the copy count, then queues it, skipping
// the divide when the new rate does not exceed the phase remainder, so that no
// copy is due. The back end sends one copy per cycle from a two-entry queue
// while it holds a run and the output is ready; output backpressure stalls the
// input only once that queue is full. The user must write the rate registers
// through the cfg port only while the stream is idle; it is not enforced.
module nearest_neighbor_resampler #(
    parameter  int SAMPLE_WIDTH = 16,
    parameter  int MAX_COPIES   = 64,
    localparam int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic [nnr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [nnr_pkg::RATE_W-1:0]    i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [TDATA_W-1:0]            s_axis_tdata,  // [SAMPLE_WIDTH-1:0] sample_in
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [TDATA_W-1:0]            m_axis_tdata,  // [SAMPLE_WIDTH-1:0] sample_out
    output logic                          m_axis_tlast
);

    localparam int CNT_W   = $clog2(MAX_COPIES + 1);
    localparam int CMD_W   = SAMPLE_WIDTH + CNT_W;

    logic                    w_push;
    logic                    w_pop;
    logic [SAMPLE_WIDTH-1:0] w_push_sample;
    logic [CNT_W-1:0]        w_push_count;
    logic [CMD_W-1:0]        w_pop_data;
    nnr_pkg::t_cmd_status    w_cmd_stat;
    logic [SAMPLE_WIDTH-1:0] w_out_sample;

    nnr_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_COPIES   (MAX_COPIES),
        .CNT_W        (CNT_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_in_sample  (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_in_last    (s_axis_tlast),
        .i_cmd_stat   (w_cmd_stat),
        .o_push       (w_push),
        .o_cmd_sample (w_push_sample),
        .o_cmd_count  (w_push_count)
    );

    nnr_cmd_fifo #(
        .WIDTH (CMD_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_count, w_push_sample}),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_stat  (w_cmd_stat)
    );

    nnr_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .CNT_W        (CNT_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_stat   (w_cmd_stat),
        .i_cmd_sample (w_pop_data[SAMPLE_WIDTH-1:0]),
        .i_cmd_count  (w_pop_data[CMD_W-1:SAMPLE_WIDTH]),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_sample     (w_out_sample),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = TDATA_W'(w_out_sample);

endmodule

>>> sv/nnr_checker.sv
`timescale 1ns / 1ps

`include "nearest_neighbor_resampler_macros.svh"

module nnr_checker #(
    parameter  int SAMPLE_WIDTH = 16,
    localparam int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [TDATA_W-1:0]            m_axis_tdata,
    input logic                          m_axis_tlast
);

    // a stalled output word holds
    `NNR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output word changed while stalled")

    // the front end is not ready in the cycle after it takes a word
    `NNR_ASSERT_NEXT(a_in_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken on back-to-back cycles")

    // inside a run the next copy follows at once with the same sample
    `NNR_ASSERT_NEXT(a_run_copy, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && $stable(m_axis_tdata), "run copy missing or changed")

    // reset empties the output register
    `NNR_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !m_axis_tvalid, "output valid right after reset")

endmodule

bind nearest_neighbor_resampler nnr_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_nnr_checker (.*);
